FILE: hw/rtl/hash_table_with_reserve_area_unit_assert.svh
// assertion macros for the hash table with reserve area unit
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef HASH_TABLE_WITH_RESERVE_AREA_UNIT_ASSERT_SVH
`define HASH_TABLE_WITH_RESERVE_AREA_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HTRA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("htra assertion failed");

`define HTRA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("htra assertion failed");

`else

`define HTRA_ASSERT_IMP(lbl, pre, post)

`define HTRA_ASSERT_NXT(lbl, pre, post)

`endif

`endif

FILE: hw/rtl/htra_pkg.sv
// shared types and constants of the hash table with reserve area unit
// no dependencies
package htra_pkg;

    localparam int KEY_W      = 64;
    localparam int CMD_W      = 2;
    localparam int PSIZE_W    = 5;
    localparam int RSIZE_W    = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    localparam int DEF_MAX_PRIMARY = 16;
    localparam int DEF_MAX_RESERVE = 4;
    localparam int DEF_KEY_BYTES   = 8;

    localparam logic [PSIZE_W-1:0] PSIZE_RST = 5'd11;
    localparam logic [RSIZE_W-1:0] RSIZE_RST = 3'd3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_PRIMARY_SIZE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESERVE_SIZE = 1'd1;

    typedef struct packed {
        logic clr;
        logic load;
        logic prep;
        logic div_step;
        logic prd;
        logic chk;
        logic rrd;
        logic rcmp;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic p_valid;
        logic p_hit;
        logic rs_empty;
        logic r_hit;
        logic r_last;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/htra_ctrl.sv
// controller state machine of the hash table with reserve area unit
// depends on htra_pkg
module htra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  htra_pkg::t_stat i_stat,
    output htra_pkg::t_cmd  o_cmd
);
    import htra_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_RRD   = 4'd6;
    localparam logic [3:0] S_RCMP  = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (!i_stat.p_valid || i_stat.p_hit || i_stat.rs_empty) n_state = S_EXEC;
                else n_state = S_RRD;
            end
            S_RRD: begin
                o_cmd.rrd = 1'b1;
                n_state   = S_RCMP;
            end
            S_RCMP: begin
                o_cmd.rcmp = 1'b1;
                if (i_stat.r_hit || i_stat.r_last) n_state = S_EXEC;
                else n_state = S_RRD;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

endmodule

FILE: hw/rtl/htra_dp.sv
// datapath of the hash table with reserve area unit: key stores, hash divider, result register
// depends on htra_pkg
module htra_dp #(
    parameter int MAX_PRIMARY = htra_pkg::DEF_MAX_PRIMARY,
    parameter int MAX_RESERVE = htra_pkg::DEF_MAX_RESERVE,
    parameter int KEY_BYTES   = htra_pkg::DEF_KEY_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [htra_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [htra_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [htra_pkg::CMD_W-1:0]      i_op,
    input  logic [htra_pkg::KEY_W-1:0]      i_key,
    input  htra_pkg::t_cmd                  i_cmd,
    output htra_pkg::t_stat                 o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_found,
    output logic                            o_error
);
    import htra_pkg::*;

    localparam int HI_W   = (MAX_PRIMARY > 1) ? $clog2(MAX_PRIMARY) : 1;
    localparam int RI_W   = (MAX_RESERVE > 1) ? $clog2(MAX_RESERVE) : 1;
    localparam int FILL_W = $clog2(MAX_RESERVE + 1);
    localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
    localparam int DCNT_W = $clog2(SUM_W);

    // configuration
    logic [PSIZE_W-1:0] r_primary_size;
    logic [RSIZE_W-1:0] r_reserve_size;
    logic [PSIZE_W-1:0] w_eff_p;
    logic               w_room;

    // item registers
    logic [CMD_W-1:0]  r_op;
    logic [KEY_W-1:0]  r_raw;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  w_canon;
    logic [SUM_W-1:0]  w_sum;
    logic [7:0]        w_byte;
    logic              w_alive;

    // hash divider
    logic [SUM_W-1:0]   r_dividend;
    logic [PSIZE_W-1:0] r_rem;
    logic [PSIZE_W-1:0] r_div;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic [PSIZE_W:0]   w_trial;
    logic [PSIZE_W:0]   w_trial_res;
    logic [HI_W-1:0]    w_home;

    // primary store, valid bit kept with the key
    logic [KEY_W:0]   r_pmem [MAX_PRIMARY];
    logic [KEY_W:0]   r_pword;
    logic [HI_W-1:0]  r_clr_addr;
    logic             w_pwe;
    logic [HI_W-1:0]  w_paddr;
    logic [KEY_W:0]   w_pwdata;

    // reserve store
    logic [KEY_W-1:0]       r_rmem [MAX_RESERVE];
    logic [MAX_RESERVE-1:0] r_rvalid;
    logic [KEY_W-1:0]       r_rword;
    logic [FILL_W-1:0]      r_fill;
    logic [RI_W-1:0]        r_ridx;
    logic [RI_W-1:0]        r_rslot;
    logic                   w_rwe;

    // lookup flags
    logic r_home_valid;
    logic r_home_hit;
    logic r_rfound;
    logic w_found;
    logic w_res_found;
    logic w_res_error;

    always_comb begin
        if (r_primary_size == '0) w_eff_p = PSIZE_W'(1);
        else if (int'(r_primary_size) > MAX_PRIMARY) w_eff_p = PSIZE_W'(MAX_PRIMARY);
        else w_eff_p = r_primary_size;
    end

    assign w_room = (int'(r_fill) < int'(r_reserve_size)) && (int'(r_fill) < MAX_RESERVE);

    // key ends at its first zero byte
    always_comb begin
        w_alive = 1'b1;
        w_canon = '0;
        w_sum   = '0;
        w_byte  = '0;
        for (int i = 0; i < 8; i++) begin
            w_byte = r_raw[8*i +: 8];
            if (i >= KEY_BYTES || w_byte == 8'd0) w_alive = 1'b0;
            if (w_alive) begin
                w_canon[8*i +: 8] = w_byte;
                w_sum = w_sum + SUM_W'(w_byte);
            end
        end
    end

    // restoring remainder, one dividend bit per cycle
    assign w_trial     = {r_rem, r_dividend[SUM_W-1]};
    assign w_trial_res = (w_trial >= {1'b0, r_div}) ? (w_trial - {1'b0, r_div}) : w_trial;
    assign w_home      = HI_W'(r_rem);

    assign w_found = r_home_valid && (r_home_hit || r_rfound);

    always_comb begin
        w_res_found = w_found;
        w_res_error = 1'b0;
        w_pwe       = 1'b0;
        w_paddr     = w_home;
        w_pwdata    = {1'b1, r_key};
        w_rwe       = 1'b0;
        if (i_cmd.clr) begin
            w_pwe    = 1'b1;
            w_paddr  = r_clr_addr;
            w_pwdata = '0;
        end else if (i_cmd.exec) begin
            case (r_op)
                CMD_INSERT: begin
                    if (w_found) w_res_error = 1'b1;
                    else if (!r_home_valid) w_pwe = 1'b1;
                    else if (w_room) w_rwe = 1'b1;
                    else w_res_error = 1'b1;
                end
                CMD_REMOVE: begin
                    if (r_home_hit) begin
                        w_pwe    = 1'b1;
                        w_pwdata = {1'b0, r_key};
                    end
                end
                CMD_SEARCH: begin
                    w_res_found = w_found;
                end
                default: begin
                    w_res_found = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) r_pmem[w_paddr] <= w_pwdata;
        if (i_cmd.prd) r_pword <= r_pmem[w_home];
        if (w_rwe) r_rmem[r_fill[RI_W-1:0]] <= r_key;
        if (i_cmd.rrd) r_rword <= r_rmem[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_raw <= i_key;
        end
        if (i_cmd.prep) begin
            r_key      <= w_canon;
            r_dividend <= w_sum;
            r_div      <= w_eff_p;
        end
        if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
        end
        if (i_cmd.chk) begin
            r_ridx <= '0;
        end else if (i_cmd.rcmp && !o_stat.r_hit) begin
            r_ridx <= r_ridx + RI_W'(1);
        end
        if (i_cmd.rcmp && o_stat.r_hit) r_rslot <= r_ridx;
        if (i_cmd.exec) begin
            o_found <= w_res_found;
            o_error <= w_res_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_size <= PSIZE_RST;
            r_reserve_size <= RSIZE_RST;
            r_rem          <= '0;
            r_div_cnt      <= '0;
            r_clr_addr     <= '0;
            r_rvalid       <= '0;
            r_fill         <= '0;
            r_home_valid   <= 1'b0;
            r_home_hit     <= 1'b0;
            r_rfound       <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PRIMARY_SIZE: r_primary_size <= i_cfg_wdata;
                    CFG_RESERVE_SIZE: r_reserve_size <= i_cfg_wdata[RSIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + HI_W'(1);
            if (i_cmd.prep) begin
                r_rem     <= '0;
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_rem     <= w_trial_res[PSIZE_W-1:0];
                r_div_cnt <= r_div_cnt + DCNT_W'(1);
            end
            if (i_cmd.chk) begin
                r_home_valid <= o_stat.p_valid;
                r_home_hit   <= o_stat.p_hit;
                r_rfound     <= 1'b0;
            end else if (i_cmd.rcmp && o_stat.r_hit) begin
                r_rfound <= 1'b1;
            end
            if (w_rwe) begin
                r_rvalid[r_fill[RI_W-1:0]] <= 1'b1;
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.exec && r_op == CMD_REMOVE && !r_home_hit && r_rfound) begin
                r_rvalid[r_rslot] <= 1'b0;
            end
            if (i_cmd.exec) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    assign o_stat.clr_last = (int'(r_clr_addr) == MAX_PRIMARY - 1);
    assign o_stat.div_last = (int'(r_div_cnt) == SUM_W - 1);
    assign o_stat.p_valid  = r_pword[KEY_W];
    assign o_stat.p_hit    = r_pword[KEY_W] && (r_pword[KEY_W-1:0] == r_key);
    assign o_stat.rs_empty = (r_fill == '0);
    assign o_stat.r_hit    = r_rvalid[r_ridx] && (r_rword == r_key);
    assign o_stat.r_last   = ((FILL_W'(r_ridx) + FILL_W'(1)) == r_fill);
    assign o_stat.out_free = !o_out_valid || i_out_ready;

endmodule

FILE: hw/rtl/hash_table_with_reserve_area_unit.sv
// One item (insert, search or remove of a key) is processed at a time. Its result is offered
// on o_m_tvalid after the steps prep, divide (one remainder bit per cycle over SUM_W, the width
// of the key byte sum, 11 for eight-byte keys), primary read, check, and a read through the
// reserve memory port and a compare for each of the s reserve slots scanned (at most the
// reserve fill), then execute. The next input is taken in the same cycle as the result is
// offered, so an item holds the input until its result is offered. A new item is taken while
// the last result waits to be transferred, and its own result is held back until that one is
// gone. After reset the primary store is cleared with s_tready low; configuration writes are
// taken at any time.
// depends on htra_pkg, htra_ctrl, htra_dp and the assertion macro header
`include "hash_table_with_reserve_area_unit_assert.svh"

module hash_table_with_reserve_area_unit #(
    parameter int MAX_PRIMARY = htra_pkg::DEF_MAX_PRIMARY,
    parameter int MAX_RESERVE = htra_pkg::DEF_MAX_RESERVE,
    parameter int KEY_BYTES   = htra_pkg::DEF_KEY_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [htra_pkg::IN_DATA_W-1:0]  i_s_tdata,   // command[1:0], key[65:2], zero pad
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [htra_pkg::OUT_DATA_W-1:0] o_m_tdata,   // found[0], error[1], zero pad
    input  logic                            i_cfg_we,
    input  logic [htra_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [htra_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import htra_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic w_found;
    logic w_error;

    htra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    htra_dp #(
        .MAX_PRIMARY (MAX_PRIMARY),
        .MAX_RESERVE (MAX_RESERVE),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_tdata[CMD_W-1:0]),
        .i_key       (i_s_tdata[CMD_W +: KEY_W]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_found     (w_found),
        .o_error     (w_error)
    );

    assign o_m_tdata = {(OUT_DATA_W-2)'(0), w_error, w_found};

    `HTRA_ASSERT_IMP(a_clear_after_reset, $past(!i_rst_n), !o_s_tready)
    `HTRA_ASSERT_NXT(a_busy_after_transfer, i_s_tvalid && o_s_tready,
        !o_s_tready && !$rose(o_m_tvalid))
    `HTRA_ASSERT_NXT(a_exec_gives_result, w_cmd.exec, o_m_tvalid)

endmodule

FILE: bench/hash_table_with_reserve_area_unit_test.sv
`timescale 1ns / 1ps
// testbench for the hash table with reserve area unit: directed table, then random
// insert/search/remove traffic over several size settings, checked by a local predictor
// depends on htra_pkg and hash_table_with_reserve_area_unit
module hash_table_with_reserve_area_unit_test;
    import htra_pkg::*;

    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 128;
    localparam int NUM_DIRECT  = 24;
    localparam int POOL_SIZE   = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        bit found;
        bit err;
    } t_flags;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        bit               typed;
        t_flags           want;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    hash_table_with_reserve_area_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),      // command[1:0], key[65:2], zero pad
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),      // found[0], error[1], zero pad
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [KEY_W-1:0]   slot_key [DEF_MAX_PRIMARY];
    bit                 slot_used [DEF_MAX_PRIMARY];
    logic [KEY_W-1:0]   spill_key [DEF_MAX_RESERVE];
    bit                 spill_used [DEF_MAX_RESERVE];
    int unsigned        spill_fill;
    logic [PSIZE_W-1:0] psize_reg;
    logic [RSIZE_W-1:0] rsize_reg;

    t_flags pending_flags [$];
    int     mismatch_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_tog = 1'b0;
    bit     hold_seen = 1'b0;
    int     hold_left = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               key_len [POOL_SIZE];

    localparam int SEND_IDLE [NUM_PHASES] = '{0, 62, 0, 9, 0, 62, 0, 9, 0};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 62, 9, 0, 0, 62, 9, 0};
    localparam int PHASE_PSIZE [NUM_PHASES] = '{1, 16, 0, 31, 5, -1, -1, 11, 16};
    localparam int PHASE_RSIZE [NUM_PHASES] = '{0, 4, 7, 5, 2, -1, -1, 3, 4};

    // at reset sizes 11 and 3; 'A' homes to slot 10, as do 'L', 'W', 'b' and 'm'
    t_dir_row dir_rows [NUM_DIRECT] = '{
        '{CMD_SEARCH, 64'h41,                  1'b1, 2'b00},
        '{CMD_REMOVE, 64'h41,                  1'b1, 2'b00},
        '{CMD_INSERT, 64'h41,                  1'b1, 2'b00},
        '{CMD_INSERT, 64'h41,                  1'b1, 2'b11},
        '{CMD_INSERT, 64'hFFFF_0000_0000_0041, 1'b1, 2'b11},
        '{CMD_INSERT, 64'h4C,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'h57,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'h62,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'h6D,                  1'b0, 2'b00},
        '{CMD_SEARCH, 64'h57,                  1'b0, 2'b00},
        '{CMD_REMOVE, 64'h4C,                  1'b0, 2'b00},
        '{CMD_SEARCH, 64'h57,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'h4C,                  1'b0, 2'b00},
        '{CMD_REMOVE, 64'h41,                  1'b0, 2'b00},
        '{CMD_SEARCH, 64'h57,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'h57,                  1'b0, 2'b00},
        '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'b00},
        '{CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'b00},
        '{CMD_INSERT, 64'h0,                   1'b0, 2'b00},
        '{CMD_SEARCH, 64'h0,                   1'b0, 2'b00},
        '{CMD_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'b00},
        '{CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'b00},
        '{CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'b00},
        '{CMD_INSERT, 64'h0102_0304_0506_0700, 1'b0, 2'b00}
    };

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_table();
        for (int i = 0; i < DEF_MAX_PRIMARY; i++) slot_used[i] = 1'b0;
        for (int i = 0; i < DEF_MAX_RESERVE; i++) spill_used[i] = 1'b0;
        spill_fill = 0;
        psize_reg = PSIZE_RST;
        rsize_reg = RSIZE_RST;
    endfunction

    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] raw,
                                          output bit found, output bit err);
        logic [KEY_W-1:0] k;
        int unsigned      sum;
        int unsigned      eff_p;
        int unsigned      eff_r;
        int unsigned      home;
        int unsigned      scan_n;
        int               rslot;
        bit               home_hit;
        k = '0;
        sum = 0;
        for (int i = 0; i < DEF_KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'd0) break;
            k[8*i +: 8] = raw[8*i +: 8];
            sum += raw[8*i +: 8];
        end
        eff_p = (psize_reg == 0) ? 1 : (psize_reg > DEF_MAX_PRIMARY) ? DEF_MAX_PRIMARY
                                                                     : psize_reg;
        eff_r = (rsize_reg > DEF_MAX_RESERVE) ? DEF_MAX_RESERVE : rsize_reg;
        home = sum % eff_p;
        found = 1'b0;
        err = 1'b0;
        home_hit = 1'b0;
        rslot = -1;
        if (slot_used[home]) begin
            if (slot_key[home] == k) begin
                home_hit = 1'b1;
                found = 1'b1;
            end else begin
                scan_n = (spill_fill > DEF_MAX_RESERVE) ? DEF_MAX_RESERVE : spill_fill;
                for (int i = 0; i < scan_n; i++) begin
                    if (spill_used[i] && spill_key[i] == k) begin
                        rslot = i;
                        break;
                    end
                end
                found = (rslot >= 0);
            end
        end
        case (cmd)
            CMD_INSERT: begin
                if (found) begin
                    err = 1'b1;
                end else if (!slot_used[home]) begin
                    slot_key[home] = k;
                    slot_used[home] = 1'b1;
                end else if (spill_fill < eff_r && spill_fill < DEF_MAX_RESERVE) begin
                    spill_key[spill_fill] = k;
                    spill_used[spill_fill] = 1'b1;
                    spill_fill++;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (home_hit) slot_used[home] = 1'b0;
                else if (rslot >= 0) spill_used[rslot] = 1'b0;
            end
            CMD_NONE: found = 1'b0;
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input bit typed, input t_flags typed_flags);
        int     gaps;
        bit     f;
        bit     e;
        t_flags pred;
        gaps = 0;
        while ($urandom_range(99) < send_idle_pct) gaps++;
        if (gaps > 0) begin
            s_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {{(IN_DATA_W-KEY_W-CMD_W){1'b0}}, key, cmd};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        apply_command(cmd, key, f, e);
        pred.found = f;
        pred.err = e;
        pending_flags.push_back(typed ? typed_flags : pred);
    endtask

    task automatic write_sizes(input logic [PSIZE_W-1:0] psize, input logic [2:0] rsize);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_PRIMARY_SIZE;
        cfg_wdata <= psize;
        @(posedge clk);
        cfg_addr <= CFG_RESERVE_SIZE;
        cfg_wdata <= {2'($urandom), rsize};
        @(posedge clk);
        cfg_we <= 1'b0;
        psize_reg = psize;
        rsize_reg = rsize;
    endtask

    task automatic wait_drained();
        while (pending_flags.size() > 0) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int               idx;
        logic [KEY_W-1:0] k;
        if ($urandom_range(3) == 0) return {$urandom, $urandom};
        idx = $urandom_range(POOL_SIZE - 1);
        k = key_pool[idx];
        // junk after the terminating zero byte must be ignored
        if (key_len[idx] < 7 && $urandom_range(3) == 0) begin
            for (int b = key_len[idx] + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    always @(posedge clk) begin
        t_flags want;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (pending_flags.size() == 0) begin
                    report_mismatch("result with no pending transfer", m_data[0], 0);
                end else begin
                    want = pending_flags.pop_front();
                    if (m_data[0] !== want.found) report_mismatch("found", m_data[0], want.found);
                    if (m_data[1] !== want.err) report_mismatch("error", m_data[1], want.err);
                end
            end
            if (hold_tog != hold_seen) begin
                hold_seen <= hold_tog;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int               n;
        logic [KEY_W-1:0] k;
        logic [CMD_W-1:0] cmd;
        int               r;
        logic [4:0]       psize;
        logic [2:0]       rsize;

        for (int i = 0; i < POOL_SIZE; i++) begin
            key_len[i] = (i == 0) ? 0 : $urandom_range(1, 8);
            k = '0;
            for (int b = 0; b < key_len[i]; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
            key_pool[i] = k;
        end
        clear_table();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECT; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
        s_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            psize = (PHASE_PSIZE[ph] < 0) ? 5'($urandom_range(31)) : 5'(PHASE_PSIZE[ph]);
            rsize = (PHASE_RSIZE[ph] < 0) ? 3'($urandom_range(7)) : 3'(PHASE_RSIZE[ph]);
            write_sizes(psize, rsize);
            send_idle_pct = SEND_IDLE[ph];
            stall_pct <= RECV_STALL[ph];
            // long receiver hold while the sender keeps offering
            if (ph == 4) hold_tog <= ~hold_tog;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 6 && i == PHASE_ITEMS / 2) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
                r = $urandom_range(99);
                cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_SEARCH :
                      (r < 95) ? CMD_REMOVE : CMD_NONE;
                send_item(cmd, pick_key(), 1'b0, 2'b00);
            end
            s_valid <= 1'b0;
        end

        n = 0;
        while (pending_flags.size() > 0 && n < 20000) begin
            @(posedge clk);
            n++;
        end
        if (pending_flags.size() > 0)
            report_mismatch("results never transferred", 0, pending_flags.size());
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/htra_pkg.sv
hw/rtl/htra_ctrl.sv
hw/rtl/htra_dp.sv
hw/rtl/hash_table_with_reserve_area_unit.sv
bench/hash_table_with_reserve_area_unit_test.sv
